>>> hw/rtl/tasi_pkg.sv
// Shared constants and control types for the three-axis step interpolator.
package tasi_pkg;

    localparam int COUNT_BITS = 20;
    localparam int DIST_W     = 12;
    localparam int SPU_W      = 8;
    localparam int PROD_W     = DIST_W + SPU_W;
    localparam int WIDE_W     = 34;
    localparam int NUM_AXES   = 3;

    localparam logic [WIDE_W-1:0] CNT_MAX = (WIDE_W'(1) << COUNT_BITS) - WIDE_W'(1);

    localparam logic [SPU_W-1:0] SPU_RESET = SPU_W'(16);

    localparam logic IN_OP_START = 1'b0;
    localparam logic IN_OP_TICK  = 1'b1;

    localparam logic REG_IDX_SPU = 1'b0;

    typedef struct packed {
        logic                  load;
        logic                  tick;
        logic [COUNT_BITS-1:0] largest;
        logic [COUNT_BITS-1:0] acc_init;
    } tasi_ctrl_t;

endpackage

>>> hw/rtl/tasi_axis.sv
// One axis of the interpolator: step count, accumulator and step decision.
module tasi_axis (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tasi_pkg::tasi_ctrl_t            ctrl,
    input  logic [tasi_pkg::COUNT_BITS-1:0] count_in,
    output logic                            step
);

    logic [tasi_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [tasi_pkg::COUNT_BITS-1:0] acc_reg, acc_next;
    logic [tasi_pkg::COUNT_BITS:0]   sum;
    logic [tasi_pkg::COUNT_BITS:0]   diff;
    logic                            hit;

    // Accumulator stays below largest, count never exceeds it: sum fits one extra bit.
    assign sum  = {1'b0, acc_reg} + {1'b0, count_reg};
    assign hit  = sum >= {1'b0, ctrl.largest};
    assign diff = sum - {1'b0, ctrl.largest};
    assign step = ctrl.tick & hit;

    always_comb begin
        count_next = count_reg;
        acc_next   = acc_reg;
        if (ctrl.load) begin
            count_next = count_in;
            acc_next   = ctrl.acc_init;
        end else if (ctrl.tick) begin
            acc_next = hit ? diff[tasi_pkg::COUNT_BITS-1:0] : sum[tasi_pkg::COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            acc_reg   <= '0;
        end else begin
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

>>> hw/rtl/three_axis_step_interpolator_top.sv
// Path from input transfer to result transfer: scale into the input register, then step
// into the output register.
// Throughput: one item per cycle; the input register takes an item while a result waits,
// and holds off only when it is full as well.
// Each tick is one add-compare-subtract per axis plus a tick counter decrement.
// Reset (aresetn low, synchronous): clears the move, directions and valid flags,
// and sets steps_per_unit to 16.
module three_axis_step_interpolator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // dist_x[11:0], dist_y[23:12], dist_z[35:24], zero pad
    input  logic        s_axis_tuser,  // operation
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // step_x, step_y, step_z, dir_x, dir_y, dir_z, zero pad
    output logic        m_axis_tlast   // move_done
);

    localparam int CB = tasi_pkg::COUNT_BITS;
    localparam int DW = tasi_pkg::DIST_W;
    localparam int NA = tasi_pkg::NUM_AXES;

    // configuration
    logic [tasi_pkg::SPU_W-1:0] spu_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == tasi_pkg::REG_IDX_SPU) ? {24'd0, spu_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spu_reg <= tasi_pkg::SPU_RESET;
        end else if (cfg_wr && paddr[2] == tasi_pkg::REG_IDX_SPU) begin
            spu_reg <= pwdata[tasi_pkg::SPU_W-1:0];
        end
    end

    // scale stage: magnitudes times steps_per_unit, saturated to the count width
    logic [CB-1:0] cnt_scaled [NA];
    logic [NA-1:0] neg_in;

    always_comb begin
        logic [DW-1:0]               dist_raw;
        logic [DW-1:0]               mag;
        logic [tasi_pkg::PROD_W-1:0] prod;
        logic [tasi_pkg::WIDE_W-1:0] prod_wide;
        for (int i = 0; i < NA; i++) begin
            dist_raw  = s_axis_tdata[i*DW +: DW];
            neg_in[i] = dist_raw[DW-1];
            mag       = dist_raw[DW-1] ? (~dist_raw + DW'(1)) : dist_raw;
            prod      = tasi_pkg::PROD_W'(mag) * tasi_pkg::PROD_W'(spu_reg);
            prod_wide = tasi_pkg::WIDE_W'(prod);
            cnt_scaled[i] = (prod_wide > tasi_pkg::CNT_MAX) ? tasi_pkg::CNT_MAX[CB-1:0]
                                                            : prod_wide[CB-1:0];
        end
    end

    logic          in_valid_reg;
    logic          in_op_reg;
    logic [CB-1:0] in_cnt_reg [NA];
    logic [NA-1:0] in_neg_reg;
    logic          advance;

    assign advance       = in_valid_reg & (~m_axis_tvalid | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg  <= s_axis_tuser;
            in_cnt_reg <= cnt_scaled;
            in_neg_reg <= neg_in;
        end
    end

    // step stage: move state and per-axis accumulators
    logic [CB-1:0] largest_reg, largest_next;
    logic [CB-1:0] ticks_reg, ticks_next;
    logic [NA-1:0] dir_reg, dir_next;
    logic [CB-1:0] big01, big;
    logic [NA-1:0] steps;
    logic          is_start, is_tick;
    logic          done;
    tasi_pkg::tasi_ctrl_t ctrl;

    assign big01 = (in_cnt_reg[0] > in_cnt_reg[1]) ? in_cnt_reg[0] : in_cnt_reg[1];
    assign big   = (big01 > in_cnt_reg[2]) ? big01 : in_cnt_reg[2];

    assign is_start = advance & (in_op_reg == tasi_pkg::IN_OP_START);
    assign is_tick  = advance & (in_op_reg == tasi_pkg::IN_OP_TICK) & (ticks_reg != '0);

    assign ctrl.load     = is_start;
    assign ctrl.tick     = is_tick;
    assign ctrl.largest  = largest_reg;
    assign ctrl.acc_init = (big == '0) ? '0 : big - CB'(1);

    for (genvar g = 0; g < NA; g++) begin : g_axis
        tasi_axis u_axis (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .count_in (in_cnt_reg[g]),
            .step     (steps[g])
        );
    end

    always_comb begin
        largest_next = largest_reg;
        ticks_next   = ticks_reg;
        dir_next     = dir_reg;
        if (is_start) begin
            largest_next = big;
            ticks_next   = big;
            dir_next     = in_neg_reg;
        end else if (is_tick) begin
            ticks_next = ticks_reg - CB'(1);
        end
        done = (ticks_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            largest_reg <= '0;
            ticks_reg   <= '0;
            dir_reg     <= '0;
        end else begin
            largest_reg <= largest_next;
            ticks_reg   <= ticks_next;
            dir_reg     <= dir_next;
        end
    end

    // output register
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, dir_next, steps};
            out_last_reg <= done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> bench/three_axis_step_interpolator_top_tb.sv
// Self-checking stream testbench for the three-axis step interpolator.
`timescale 1ns / 100ps

module three_axis_step_interpolator_top_tb;

    localparam logic [2:0] SPU_ADDR    = 3'(4 * tasi_pkg::REG_IDX_SPU);
    localparam logic [2:0] UNUSED_ADDR = 3'd4;
    localparam int         IDLE_PCT    = 28;
    localparam int         STALL_LIMIT = 1000;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 266;

    typedef struct packed {
        logic                        op;
        logic [tasi_pkg::DIST_W-1:0] dist_x;
        logic [tasi_pkg::DIST_W-1:0] dist_y;
        logic [tasi_pkg::DIST_W-1:0] dist_z;
    } axis_cmd_t;

    typedef struct packed {
        logic [tasi_pkg::NUM_AXES-1:0] step;
        logic [tasi_pkg::NUM_AXES-1:0] dir;
        logic                          done;
    } step_word_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // dist_x, dist_y, dist_z, zero pad
    logic        s_axis_tuser  = 1'b0; // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // step_x, step_y, step_z, dir_x, dir_y, dir_z, zero pad
    logic        m_axis_tlast;        // move_done

    three_axis_step_interpolator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    axis_cmd_t  pending_cmds[$];
    step_word_t expected_steps[$];
    int         mismatches  = 0;
    int         idle_cycles = 0;
    bit         calm_run    = 1'b0;
    string      axis_tag[tasi_pkg::NUM_AXES] = '{"x", "y", "z"};

    // predictor state
    logic [tasi_pkg::SPU_W-1:0]      spu_setting = tasi_pkg::SPU_RESET;
    logic [tasi_pkg::COUNT_BITS-1:0] axis_cnt[tasi_pkg::NUM_AXES];
    logic [tasi_pkg::COUNT_BITS-1:0] axis_acc[tasi_pkg::NUM_AXES];
    logic [tasi_pkg::COUNT_BITS-1:0] move_largest;
    logic [tasi_pkg::COUNT_BITS-1:0] move_ticks_left;
    logic [tasi_pkg::NUM_AXES-1:0]   axis_dirs;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Compute the result of one accepted command and queue it.
    task automatic advance_axes(input axis_cmd_t cmd);
        step_word_t                      r;
        logic [tasi_pkg::DIST_W-1:0]     raw[tasi_pkg::NUM_AXES];
        logic [tasi_pkg::DIST_W:0]       mag;
        logic [tasi_pkg::WIDE_W-1:0]     prod;
        logic [tasi_pkg::COUNT_BITS:0]   sum;
        logic [tasi_pkg::COUNT_BITS-1:0] big;
        raw[0] = cmd.dist_x;
        raw[1] = cmd.dist_y;
        raw[2] = cmd.dist_z;
        r = '0;
        if (cmd.op == tasi_pkg::IN_OP_START) begin
            big = '0;
            for (int i = 0; i < tasi_pkg::NUM_AXES; i++) begin
                mag  = raw[i][tasi_pkg::DIST_W-1] ? (13'h1000 - {1'b0, raw[i]})
                                                  : {1'b0, raw[i]};
                prod = tasi_pkg::WIDE_W'(mag) * tasi_pkg::WIDE_W'(spu_setting);
                if (prod > tasi_pkg::CNT_MAX)
                    prod = tasi_pkg::CNT_MAX;
                axis_cnt[i]  = prod[tasi_pkg::COUNT_BITS-1:0];
                axis_dirs[i] = raw[i][tasi_pkg::DIST_W-1];
                if (axis_cnt[i] > big)
                    big = axis_cnt[i];
            end
            move_largest    = big;
            move_ticks_left = big;
            for (int i = 0; i < tasi_pkg::NUM_AXES; i++)
                axis_acc[i] = (big == 0) ? '0 : big - tasi_pkg::COUNT_BITS'(1);
        end else if (move_ticks_left != 0) begin
            for (int i = 0; i < tasi_pkg::NUM_AXES; i++) begin
                sum = {1'b0, axis_acc[i]} + {1'b0, axis_cnt[i]};
                if (sum >= {1'b0, move_largest}) begin
                    sum       = sum - {1'b0, move_largest};
                    r.step[i] = 1'b1;
                end
                axis_acc[i] = sum[tasi_pkg::COUNT_BITS-1:0];
            end
            move_ticks_left = move_ticks_left - tasi_pkg::COUNT_BITS'(1);
        end
        r.dir  = axis_dirs;
        r.done = (move_ticks_left == 0);
        expected_steps.push_back(r);
    endtask

    // input driver: predict on each transfer, then present the next command
    always @(posedge aclk) begin : cmd_driver
        axis_cmd_t on_bus;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                advance_axes(on_bus);
            if (pending_cmds.size() != 0 && (calm_run || $urandom_range(99) >= IDLE_PCT)) begin
                on_bus = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, on_bus.dist_z, on_bus.dist_y, on_bus.dist_x};
                s_axis_tuser  <= on_bus.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor: stall at random and compare each transfer
    always @(posedge aclk) begin : step_monitor
        step_word_t want;
        m_axis_tready <= calm_run || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_steps.size() == 0) begin
                flag_mismatch($sformatf("result %h with nothing pending", m_axis_tdata));
            end else begin
                want = expected_steps.pop_front();
                for (int i = 0; i < tasi_pkg::NUM_AXES; i++) begin
                    if (m_axis_tdata[i] !== want.step[i])
                        flag_mismatch($sformatf("step_%s got %b want %b", axis_tag[i],
                                                m_axis_tdata[i], want.step[i]));
                    if (m_axis_tdata[tasi_pkg::NUM_AXES+i] !== want.dir[i])
                        flag_mismatch($sformatf("dir_%s got %b want %b", axis_tag[i],
                                                m_axis_tdata[tasi_pkg::NUM_AXES+i],
                                                want.dir[i]));
                end
                if (m_axis_tlast !== want.done)
                    flag_mismatch($sformatf("move_done got %b want %b", m_axis_tlast, want.done));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [tasi_pkg::SPU_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == SPU_ADDR)
            spu_setting = value;
    endtask

    task automatic push_start(input int dx, input int dy, input int dz);
        pending_cmds.push_back('{tasi_pkg::IN_OP_START, tasi_pkg::DIST_W'(dx),
                                 tasi_pkg::DIST_W'(dy), tasi_pkg::DIST_W'(dz)});
    endtask

    task automatic push_ticks(input int n);
        repeat (n)
            pending_cmds.push_back('{tasi_pkg::IN_OP_TICK, '0, '0, '0});
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_steps.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly full moves with small distances; some cut short, some raw noise.
    task automatic queue_moves(input int budget, input int spu);
        int added;
        int lim;
        int big;
        int ticks;
        int d[tasi_pkg::NUM_AXES];
        int mag;
        added = 0;
        while (added < budget) begin
            if ($urandom_range(99) < 8) begin
                pending_cmds.push_back('{1'($urandom_range(1)), tasi_pkg::DIST_W'($urandom),
                                         tasi_pkg::DIST_W'($urandom),
                                         tasi_pkg::DIST_W'($urandom)});
                added++;
            end else begin
                if (spu == 0)
                    lim = 2048;
                else
                    lim = (48 / spu > 0) ? 48 / spu : 1;
                big = 0;
                for (int i = 0; i < tasi_pkg::NUM_AXES; i++) begin
                    d[i] = $urandom_range(2 * lim) - lim;
                    if (d[i] > 2047)
                        d[i] = 2047;
                    mag = (d[i] < 0) ? -d[i] : d[i];
                    if (mag * spu > big)
                        big = mag * spu;
                end
                push_start(d[0], d[1], d[2]);
                ticks = big + $urandom_range(3);
                if ($urandom_range(99) < 15)
                    ticks = $urandom_range(ticks);
                push_ticks(ticks);
                added += 1 + ticks;
            end
        end
    endtask

    initial begin : stimulus
        int spu_plan[PHASES];
        spu_plan = '{16, 1, 255, 0, 160, 0};
        spu_plan[PHASES-1] = $urandom_range(254, 2);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                if (p == 3)
                    write_reg(UNUSED_ADDR, tasi_pkg::SPU_W'($urandom));
                write_reg(SPU_ADDR, tasi_pkg::SPU_W'(spu_plan[p]));
            end
            calm_run = (p == 1);
            if (p == 0) begin
                // idle tick straight out of reset
                push_ticks(1);
                // distance extremes, replaced mid-move
                push_start(2047, -2048, 0);
                push_ticks(2);
                push_start(-1, 1, -2048);
                push_ticks(1);
                // zero move, then an idle tick
                push_start(0, 0, 0);
                push_ticks(1);
                // three-way tie run to the end and past it
                push_start(-1, -1, 1);
                push_ticks(18);
            end
            queue_moves(PHASE_ITEMS, spu_plan[p]);
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
